// ----- src/hbs_pkg.sv -----
// Package for the heightmap bilinear sampler: widths, register indexes,
// sequencer states, the queue entry and configuration structs, helpers.
// No dependencies.
package hbs_pkg;

    // Fixed-point fraction width of grid coordinates
    localparam int FRAC_BITS     = 16;

    // Defaults for the grid size parameters
    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_MAX_DEPTH = 64;

    // Widths fixed by the item fields
    localparam int TEXEL_W       = 8;
    localparam int ROWCOL_W      = 6;
    localparam int POS_W         = 32;
    localparam int INV_W         = 24;
    localparam int HEIGHT_W      = 32;
    localparam int GRID_REG_W    = 7;
    localparam int IDX_W         = 8;    // texel index, covers sizes up to 256
    localparam int SIZE_W        = 9;    // size value, holds 256 itself

    // Stream payload layout (slave side tdata)
    localparam int ROW_LSB       = 0;
    localparam int COL_LSB       = ROW_LSB + ROWCOL_W;
    localparam int VALUE_LSB     = COL_LSB + ROWCOL_W;
    localparam int POSX_LSB      = VALUE_LSB + TEXEL_W;
    localparam int POSZ_LSB      = POSX_LSB + POS_W;
    localparam int S_TDATA_W     = ((POSZ_LSB + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = HEIGHT_W;

    // Configuration port
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Queue between front and back
    localparam int QUEUE_DEPTH   = 4;

    // Register reset values
    localparam logic [GRID_REG_W-1:0] RST_GRID_WIDTH    = 7'd64;
    localparam logic [GRID_REG_W-1:0] RST_GRID_DEPTH    = 7'd64;
    localparam logic [INV_W-1:0]      RST_INV_CELL_SIZE = 24'd65536;
    localparam logic signed [31:0]    RST_BASE_HEIGHT   = 32'sd0;
    localparam logic signed [31:0]    RST_HEIGHT_GAIN   = 32'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH    = 3'd0,
        REG_GRID_DEPTH    = 3'd1,
        REG_INV_CELL_SIZE = 3'd2,
        REG_BASE_HEIGHT   = 3'd3,
        REG_HEIGHT_GAIN   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RD1,
        SEQ_RD2,
        SEQ_RD3
    } seq_state_t;

    typedef struct packed {
        logic [GRID_REG_W-1:0] grid_width;
        logic [GRID_REG_W-1:0] grid_depth;
        logic [INV_W-1:0]      inv_cell_size;
        logic signed [31:0]    base_height;
        logic signed [31:0]    height_gain;
    } hbs_cfg_t;

    // One queued operation: a texel write or a classified query
    typedef struct packed {
        cmd_t                  cmd;
        logic                  loaded;
        logic                  wr_ok;
        logic [ROWCOL_W-1:0]   row;
        logic [ROWCOL_W-1:0]   col;
        logic [TEXEL_W-1:0]    value;
        logic [IDX_W-1:0]      ix0;
        logic [IDX_W-1:0]      ix1;
        logic [IDX_W-1:0]      iz0;
        logic [IDX_W-1:0]      iz1;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fz;
    } hbs_entry_t;

    // Clamp a size register to [2, hi]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [GRID_REG_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] ve;
        ve = SIZE_W'(v);
        if (ve < SIZE_W'(2))
            return SIZE_W'(2);
        else if (ve > hi)
            return hi;
        else
            return ve;
    endfunction

endpackage

// ----- src/heightmap_bilinear_sampler.sv -----
// Heightmap bilinear sampler, top level: configuration registers and the
// front, queue and back. A texel write is a single memory write in the back;
// a height query makes four reads, one for each neighbor, from the single-port
// texel memory, and the back pops no new operation until the last is issued.
// The front takes a new transaction every cycle while its four-entry queue
// has room. Heights are Q16.16; before a write flagged last, queries return
// height 0 with map_loaded low. Texels that were never written read as
// unknown values. Depends on hbs_pkg, hbs_front, hbs_fifo, hbs_back.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] texel_row, [11:6] texel_col, [19:12] texel_value,
    // [51:20] pos_x, [83:52] pos_z, [87:84] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // cmd
    input  logic                  s_tlast,   // last_texel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] height
    output logic                  m_tuser    // map_loaded
);

    hbs_cfg_t   cfg_reg;
    logic       push;
    hbs_entry_t push_data;
    logic       q_full;
    logic       pop;
    hbs_entry_t head;
    logic       q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width    <= RST_GRID_WIDTH;
            cfg_reg.grid_depth    <= RST_GRID_DEPTH;
            cfg_reg.inv_cell_size <= RST_INV_CELL_SIZE;
            cfg_reg.base_height   <= RST_BASE_HEIGHT;
            cfg_reg.height_gain   <= RST_HEIGHT_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:    cfg_reg.grid_width    <= cfg_data[GRID_REG_W-1:0];
                REG_GRID_DEPTH:    cfg_reg.grid_depth    <= cfg_data[GRID_REG_W-1:0];
                REG_INV_CELL_SIZE: cfg_reg.inv_cell_size <= cfg_data[INV_W-1:0];
                REG_BASE_HEIGHT:   cfg_reg.base_height   <= $signed(cfg_data[31:0]);
                REG_HEIGHT_GAIN:   cfg_reg.height_gain   <= $signed(cfg_data[31:0]);
                default: ;
            endcase
        end
    end

    hbs_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    hbs_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    hbs_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- src/hbs_front.sv -----
// Front of the heightmap sampler: accepts stream items, scales query
// positions into clamped grid coordinates and queues classified operations.
// Depends on hbs_pkg.
module hbs_front import hbs_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbs_cfg_t             cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 push,
    output hbs_entry_t           push_data,
    input  logic                 q_full
);

    localparam int PROD_W = POS_W + INV_W + 1;
    localparam int SHIFT  = POS_W - FRAC_BITS;
    localparam int G_W    = PROD_W - SHIFT + 1;
    localparam int GX_W   = FRAC_BITS + IDX_W;

    logic                      s1_vld_reg;
    cmd_t                      s1_cmd_reg;
    logic [ROWCOL_W-1:0]       s1_row_reg;
    logic [ROWCOL_W-1:0]       s1_col_reg;
    logic [TEXEL_W-1:0]        s1_value_reg;
    logic                      s1_last_reg;
    logic signed [PROD_W-1:0]  s1_prodx_reg;
    logic signed [PROD_W-1:0]  s1_prodz_reg;
    logic                      loaded_reg;

    logic                      adv;
    logic                      accept;
    logic [SIZE_W-1:0]         w_eff;
    logic [SIZE_W-1:0]         d_eff;
    logic [GX_W-1:0]           gx;
    logic [GX_W-1:0]           gz;
    logic [IDX_W-1:0]          ix0;
    logic [IDX_W-1:0]          iz0;

    // floor(prod / 2^SHIFT) + (size/2) cells, clamped to [0, size-1] cells
    function automatic logic [GX_W-1:0] grid_coord(input logic signed [PROD_W-1:0] prod,
                                                   input logic [SIZE_W-1:0] size);
        logic signed [G_W-1:0] g;
        logic signed [G_W-1:0] top;
        g   = G_W'(prod >>> SHIFT) + $signed(G_W'(size >> 1) << FRAC_BITS);
        top = $signed(G_W'(size - SIZE_W'(1)) << FRAC_BITS);
        if (g < 0)
            return '0;
        else if (g > top)
            return top[GX_W-1:0];
        else
            return g[GX_W-1:0];
    endfunction

    // Neighbor index stops at the last column or row
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                    input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(idx) + SIZE_W'(1);
        if (nxt < size)
            return nxt[IDX_W-1:0];
        else
            return IDX_W'(size - SIZE_W'(1));
    endfunction

    // Stage advances unless its item is stuck on a full queue
    assign adv      = !s1_vld_reg || !q_full;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign push     = s1_vld_reg && !q_full;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                s1_vld_reg <= s_tvalid;
            if (push && s1_cmd_reg == CMD_WRITE && s1_last_reg)
                loaded_reg <= 1'b1;
        end
    end

    // Capture fields and scale positions by the reciprocal cell size
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= cmd_t'(s_tuser);
            s1_row_reg   <= s_tdata[ROW_LSB +: ROWCOL_W];
            s1_col_reg   <= s_tdata[COL_LSB +: ROWCOL_W];
            s1_value_reg <= s_tdata[VALUE_LSB +: TEXEL_W];
            s1_last_reg  <= s_tlast;
            s1_prodx_reg <= $signed(s_tdata[POSX_LSB +: POS_W])
                            * $signed({1'b0, cfg.inv_cell_size});
            s1_prodz_reg <= $signed(s_tdata[POSZ_LSB +: POS_W])
                            * $signed({1'b0, cfg.inv_cell_size});
        end
    end

    // Grid coordinates and neighbor indexes
    always_comb
    begin
        w_eff = clamp_size(cfg.grid_width, SIZE_W'(MAX_WIDTH));
        d_eff = clamp_size(cfg.grid_depth, SIZE_W'(MAX_DEPTH));
        gx    = grid_coord(s1_prodx_reg, w_eff);
        gz    = grid_coord(s1_prodz_reg, d_eff);
        ix0   = gx[FRAC_BITS +: IDX_W];
        iz0   = gz[FRAC_BITS +: IDX_W];
    end

    // Queue entry
    always_comb
    begin
        push_data.cmd    = s1_cmd_reg;
        push_data.loaded = loaded_reg;
        push_data.wr_ok  = (SIZE_W'(s1_row_reg) < SIZE_W'(MAX_DEPTH))
                           && (SIZE_W'(s1_col_reg) < SIZE_W'(MAX_WIDTH));
        push_data.row    = s1_row_reg;
        push_data.col    = s1_col_reg;
        push_data.value  = s1_value_reg;
        push_data.ix0    = ix0;
        push_data.ix1    = next_index(ix0, w_eff);
        push_data.iz0    = iz0;
        push_data.iz1    = next_index(iz0, d_eff);
        push_data.fx     = gx[FRAC_BITS-1:0];
        push_data.fz     = gz[FRAC_BITS-1:0];
    end

    // Once loaded, the map stays loaded until reset
    assert property (@(posedge clk) disable iff (!rst_n) loaded_reg |=> loaded_reg)
        else $error("map loaded flag dropped");

endmodule

// ----- src/hbs_fifo.sv -----
// Short queue between the sampler front and back.
// Depends on hbs_pkg (entry type and depth).
module hbs_fifo import hbs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hbs_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output hbs_entry_t head,
    output logic       empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hbs_entry_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && full) |-> pop)
        else $error("push into full queue");

endmodule

// ----- src/hbs_back.sv -----
// Back of the heightmap sampler: texel memory, read sequencer for the four
// neighbors, bilinear blend, gain and offset pipeline, output register.
// Depends on hbs_pkg.
module hbs_back import hbs_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbs_cfg_t             cfg,
    input  logic                 q_empty,
    input  hbs_entry_t           head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] height
    output logic                 m_tuser    // map_loaded
);

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int A_W       = TEXEL_W + FRAC_BITS;          // one-axis blend
    localparam int P0_W      = FRAC_BITS + TEXEL_W + 2;
    localparam int V_W       = 2 * FRAC_BITS + TEXEL_W + 2;
    localparam int VR_W      = 2 * FRAC_BITS + TEXEL_W;
    localparam int PROD_W    = 32 + A_W + 1;
    localparam int TERM_W    = PROD_W - TEXEL_W - FRAC_BITS;

    localparam logic [1:0] SLOT_00 = 2'd0;
    localparam logic [1:0] SLOT_01 = 2'd1;
    localparam logic [1:0] SLOT_10 = 2'd2;
    localparam logic [1:0] SLOT_11 = 2'd3;

    localparam logic signed [TERM_W:0] H_MAX = (TERM_W+1)'(2147483647);
    localparam logic signed [TERM_W:0] H_MIN = -H_MAX - (TERM_W+1)'(1);

    seq_state_t                state_reg;
    seq_state_t                state_next;
    hbs_entry_t                cur_reg;

    logic                      adv;
    logic                      mem_we;
    logic                      mem_re;
    logic [AW-1:0]             mem_addr;
    logic [1:0]                slot;
    logic [TEXEL_W-1:0]        texel_mem [MEM_DEPTH];
    logic [TEXEL_W-1:0]        rdata_reg;
    logic                      rd_vld_reg;
    logic [1:0]                rd_slot_reg;
    logic [TEXEL_W-1:0]        t00_reg;
    logic [TEXEL_W-1:0]        t01_reg;
    logic [TEXEL_W-1:0]        t10_reg;

    logic                      b1_vld_reg;
    logic [A_W-1:0]            b1_a_reg;
    logic [A_W-1:0]            b1_b_reg;
    logic [FRAC_BITS-1:0]      b1_fz_reg;
    logic                      b1_ld_reg;
    logic                      b2_vld_reg;
    logic [A_W-1:0]            b2_vq_reg;
    logic                      b2_ld_reg;
    logic                      b3_vld_reg;
    logic signed [PROD_W-1:0]  b3_prod_reg;
    logic                      b3_ld_reg;
    logic                      out_vld_reg;
    logic [HEIGHT_W-1:0]       out_height_reg;
    logic                      out_loaded_reg;

    logic signed [TEXEL_W:0]   d0;
    logic signed [TEXEL_W:0]   d0b;
    logic signed [P0_W-1:0]    p0;
    logic signed [P0_W-1:0]    p0b;
    logic signed [P0_W-1:0]    a_sum;
    logic signed [P0_W-1:0]    b_sum;
    logic signed [A_W:0]       d1;
    logic signed [V_W-1:0]     p1;
    logic signed [V_W-1:0]     v;
    logic [VR_W-1:0]           vr;
    logic signed [PROD_W-1:0]  rsum;
    logic signed [PROD_W-1:0]  rshift;
    logic signed [TERM_W-1:0]  term;
    logic signed [TERM_W:0]    hsum;
    logic [HEIGHT_W-1:0]       hsat;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
        return AW'(AW'(r) * AW'(MAX_WIDTH) + AW'(c));
    endfunction

    // Everything in the back moves only when the output register can take a result
    assign adv      = !out_vld_reg || m_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_height_reg;
    assign m_tuser  = out_loaded_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (adv && !q_empty && head.cmd == CMD_QUERY)
                    state_next = SEQ_RD1;
            end
            SEQ_RD1:
            begin
                if (adv)
                    state_next = SEQ_RD2;
            end
            SEQ_RD2:
            begin
                if (adv)
                    state_next = SEQ_RD3;
            end
            SEQ_RD3:
            begin
                if (adv)
                    state_next = SEQ_IDLE;
            end
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop and memory port
    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = '0;
        slot     = SLOT_00;
        case (state_reg)
            SEQ_IDLE:
            begin
                pop = adv && !q_empty;
                if (head.cmd == CMD_QUERY)
                begin
                    mem_re   = pop;
                    mem_addr = addr_of(head.iz0, head.ix0);
                end
                else
                begin
                    mem_we   = pop && head.wr_ok;
                    mem_addr = addr_of(IDX_W'(head.row), IDX_W'(head.col));
                end
            end
            SEQ_RD1:
            begin
                mem_re   = adv;
                mem_addr = addr_of(cur_reg.iz0, cur_reg.ix1);
                slot     = SLOT_01;
            end
            SEQ_RD2:
            begin
                mem_re   = adv;
                mem_addr = addr_of(cur_reg.iz1, cur_reg.ix0);
                slot     = SLOT_10;
            end
            SEQ_RD3:
            begin
                mem_re   = adv;
                mem_addr = addr_of(cur_reg.iz1, cur_reg.ix1);
                slot     = SLOT_11;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Texel memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            texel_mem[mem_addr] <= head.value;
        if (mem_re)
            rdata_reg <= texel_mem[mem_addr];
    end

    // Control state of sequencer and pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            rd_vld_reg  <= 1'b0;
            rd_slot_reg <= SLOT_00;
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            b3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                rd_vld_reg  <= mem_re;
                rd_slot_reg <= slot;
                b1_vld_reg  <= rd_vld_reg && rd_slot_reg == SLOT_11;
                b2_vld_reg  <= b1_vld_reg;
                b3_vld_reg  <= b2_vld_reg;
                out_vld_reg <= b3_vld_reg;
            end
        end
    end

    // Current query and first three texels
    always_ff @(posedge clk)
    begin
        if (pop && head.cmd == CMD_QUERY)
            cur_reg <= head;
        if (adv && rd_vld_reg)
        begin
            case (rd_slot_reg)
                SLOT_00: t00_reg <= rdata_reg;
                SLOT_01: t01_reg <= rdata_reg;
                SLOT_10: t10_reg <= rdata_reg;
                default: ;
            endcase
        end
    end

    // Blend along x: t0*S + (t1 - t0)*fx, the last texel straight from memory
    always_comb
    begin
        d0    = $signed({1'b0, t01_reg}) - $signed({1'b0, t00_reg});
        d0b   = $signed({1'b0, rdata_reg}) - $signed({1'b0, t10_reg});
        p0    = d0 * $signed({1'b0, cur_reg.fx});
        p0b   = d0b * $signed({1'b0, cur_reg.fx});
        a_sum = $signed({2'b00, t00_reg, {FRAC_BITS{1'b0}}}) + p0;
        b_sum = $signed({2'b00, t10_reg, {FRAC_BITS{1'b0}}}) + p0b;
    end

    // Blend along z, round half up back to FRAC_BITS
    always_comb
    begin
        d1 = $signed({1'b0, b1_b_reg}) - $signed({1'b0, b1_a_reg});
        p1 = d1 * $signed({1'b0, b1_fz_reg});
        v  = $signed({2'b00, b1_a_reg, {FRAC_BITS{1'b0}}}) + p1;
        vr = v[VR_W-1:0] + (VR_W'(1) << (FRAC_BITS - 1));
    end

    // Scale by 1/256 with rounding, add base height and saturate
    always_comb
    begin
        rsum   = b3_prod_reg + $signed(PROD_W'(1) << (TEXEL_W - 1 + FRAC_BITS));
        rshift = rsum >>> (TEXEL_W + FRAC_BITS);
        term   = $signed(rshift[TERM_W-1:0]);
        hsum   = (TERM_W+1)'(cfg.base_height) + (TERM_W+1)'(term);
        if (hsum > H_MAX)
            hsat = 32'h7FFF_FFFF;
        else if (hsum < H_MIN)
            hsat = 32'h8000_0000;
        else
            hsat = hsum[HEIGHT_W-1:0];
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_a_reg       <= a_sum[A_W-1:0];
            b1_b_reg       <= b_sum[A_W-1:0];
            b1_fz_reg      <= cur_reg.fz;
            b1_ld_reg      <= cur_reg.loaded;
            b2_vq_reg      <= vr[VR_W-1:FRAC_BITS];
            b2_ld_reg      <= b1_ld_reg;
            b3_prod_reg    <= cfg.height_gain * $signed({1'b0, b2_vq_reg});
            b3_ld_reg      <= b2_ld_reg;
            out_height_reg <= b3_ld_reg ? hsat : '0;
            out_loaded_reg <= b3_ld_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("texel memory read and write in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg != SEQ_IDLE) |-> (cur_reg.cmd == CMD_QUERY))
        else $error("neighbor reads running for a write");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero height without a loaded map");

endmodule
